// ===== rtl/asd_pkg.sv =====
// Package with the shared constants, segment table and digit helpers of the speed display.
package asd_pkg;

    localparam int SAMPLE_BITS      = 10;
    // The mean is taken with a shift, so this stays a power of two.
    localparam int SAMPLES_PER_MEAN = 8;
    localparam int COUNT_BITS       = $clog2(SAMPLES_PER_MEAN);
    localparam int SUM_BITS         = SAMPLE_BITS + COUNT_BITS;
    localparam int SPEED_BITS       = 7;
    localparam int SEG_BITS         = 7;
    localparam int PROD_BITS        = SAMPLE_BITS + SPEED_BITS + 1;
    localparam int QUOT_BITS        = PROD_BITS - SAMPLE_BITS;

    localparam logic [SAMPLE_BITS-1:0] SAMPLE_MAX  = {SAMPLE_BITS{1'b1}};
    localparam logic [SAMPLE_BITS-1:0] SAMPLE_HALF = SAMPLE_MAX >> 1;
    localparam logic [COUNT_BITS-1:0]  COUNT_LAST  = COUNT_BITS'(SAMPLES_PER_MEAN - 1);
    localparam logic [SPEED_BITS-1:0]  SPEED_LIMIT = 7'd99;
    localparam logic [SPEED_BITS-1:0]  FULL_SCALE_RESET = 7'd50;

    localparam logic CMD_SAMPLE = 1'b0;
    localparam logic CMD_TICK   = 1'b1;

    typedef logic [SEG_BITS-1:0] t_seg;

    localparam t_seg SEG_CODES [10] = '{
        7'h77, 7'h41, 7'h3B, 7'h6B, 7'h4D, 7'h6E, 7'h7E, 7'h43, 7'h7F, 7'h4F
    };

    // Tens digit of a value below 100, by multiplying with 205/2048.
    function automatic logic [3:0] digit_tens(input logic [SPEED_BITS-1:0] v);
        logic [14:0] p;
        p = 15'(v) * 15'd205;
        return p[14:11];
    endfunction

    function automatic logic [3:0] digit_units(input logic [SPEED_BITS-1:0] v);
        logic [SPEED_BITS-1:0] t;
        logic [SPEED_BITS-1:0] u;
        t = SPEED_BITS'(digit_tens(v));
        u = v - SPEED_BITS'(t * 7'd10);
        return u[3:0];
    endfunction

endpackage

// ===== rtl/asd_if.sv =====
// Handshake interfaces for the sample, result and configuration channels.
interface asd_in_if
    import asd_pkg::*;
;
    logic                   valid;
    logic                   ready;
    logic                   command;
    logic [SAMPLE_BITS-1:0] sample;

    modport source (output valid, command, sample, input ready);
    modport sink   (input valid, command, sample, output ready);
endinterface

interface asd_out_if
    import asd_pkg::*;
;
    logic                  valid;
    logic                  ready;
    logic [SEG_BITS-1:0]   segments;
    logic                  high_digit_on;
    logic                  low_digit_on;
    logic [SPEED_BITS-1:0] speed;

    modport source (output valid, segments, high_digit_on, low_digit_on, speed,
                    input ready);
    modport sink   (input valid, segments, high_digit_on, low_digit_on, speed,
                    output ready);
endinterface

interface asd_cfg_if
    import asd_pkg::*;
;
    logic                  valid;
    logic                  ready;
    logic [SPEED_BITS-1:0] data;

    modport source (output valid, data, input ready);
    modport sink   (input valid, data, output ready);
endinterface

// ===== rtl/asd_scale.sv =====
// Scales a mean reading to a rounded speed: (mean*full_scale + half) / max, capped at 99.
module asd_scale
    import asd_pkg::*;
(
    input  logic [SAMPLE_BITS-1:0] i_mean,
    input  logic [SPEED_BITS-1:0]  i_full_scale,
    output logic [SPEED_BITS-1:0]  o_speed
);

    logic [PROD_BITS-1:0]   prod;
    logic [QUOT_BITS-1:0]   q0;
    logic [SAMPLE_BITS:0]   rem;
    logic [QUOT_BITS-1:0]   quot;

    // Division by 2^n - 1: the quotient estimate x >> n leaves a remainder of
    // (x mod 2^n) + estimate, which is below twice the divisor, so one
    // compare fixes it.
    always_comb begin
        prod = PROD_BITS'(i_mean) * PROD_BITS'(i_full_scale) + PROD_BITS'(SAMPLE_HALF);
        q0   = prod[PROD_BITS-1:SAMPLE_BITS];
        rem  = {1'b0, prod[SAMPLE_BITS-1:0]} + (SAMPLE_BITS+1)'(q0);
        quot = (rem >= {1'b0, SAMPLE_MAX}) ? q0 + 1'b1 : q0;
        if (quot > QUOT_BITS'(SPEED_LIMIT)) begin
            o_speed = SPEED_LIMIT;
        end else begin
            o_speed = quot[SPEED_BITS-1:0];
        end
    end

endmodule

// ===== rtl/adc_average_speed_display_top.sv =====
// Top level of the averaging speed display: sample accumulation, scaling and digit output.
//
//  channel   dir  fields                                         accepted when
//  i_in      in   command[0], sample[9:0]                        valid && ready
//  o_out     out  segments[6:0], high_digit_on, low_digit_on,    valid && ready
//                 speed[6:0]
//  i_cfg     in   data[6:0] (full_scale)                         valid && ready
//
// One item is taken per cycle unless a tick in the input register waits on a stalled result;
// each item is worked on in the input register, and a tick result is then loaded into
// the output register, so a result passes both registers before it is visible.
// The scaling multiply and the divide by the full reading are combinational logic.
// A stalled result holds the input register only when it holds a tick; samples
// keep flowing. Reset clears the accumulator, the speed and the digit select,
// and loads full_scale with 50. Configuration is always ready.
module adc_average_speed_display_top
    import asd_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    asd_in_if.sink    i_in,
    asd_out_if.source o_out,
    asd_cfg_if.sink   i_cfg
);

    logic                   r_s1_valid;
    logic                   r_s1_cmd;
    logic [SAMPLE_BITS-1:0] r_s1_sample;

    logic [SUM_BITS-1:0]    r_sum;
    logic [COUNT_BITS-1:0]  r_count;
    logic [SPEED_BITS-1:0]  r_speed;
    logic                   r_show_low;
    logic [SPEED_BITS-1:0]  r_full_scale;

    logic                   r_out_valid;
    t_seg                   r_out_seg;
    logic                   r_out_high;
    logic                   r_out_low;
    logic [SPEED_BITS-1:0]  r_out_speed;

    logic                   out_free;
    logic                   s1_go;
    logic [SUM_BITS-1:0]    n_sum;
    logic [SPEED_BITS-1:0]  n_speed;
    logic [3:0]             digit;

    assign out_free = !r_out_valid || o_out.ready;
    assign s1_go    = r_s1_valid && ((r_s1_cmd == CMD_SAMPLE) || out_free);
    assign i_in.ready = !r_s1_valid || s1_go;
    assign i_cfg.ready = 1'b1;

    assign n_sum = r_sum + SUM_BITS'(r_s1_sample);
    assign digit = r_show_low ? digit_units(r_speed) : digit_tens(r_speed);

    asd_scale u_scale (
        .i_mean       (n_sum[SUM_BITS-1:COUNT_BITS]),
        .i_full_scale (r_full_scale),
        .o_speed      (n_speed)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (i_in.valid && i_in.ready) begin
            r_s1_valid <= 1'b1;
        end else if (s1_go) begin
            r_s1_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in.valid && i_in.ready) begin
            r_s1_cmd    <= i_in.command;
            r_s1_sample <= i_in.sample;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_full_scale <= FULL_SCALE_RESET;
        end else if (i_cfg.valid && i_cfg.ready) begin
            r_full_scale <= i_cfg.data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sum      <= '0;
            r_count    <= '0;
            r_speed    <= '0;
            r_show_low <= 1'b0;
        end else if (s1_go) begin
            if (r_s1_cmd == CMD_SAMPLE) begin
                if (r_count == COUNT_LAST) begin
                    r_speed <= n_speed;
                    r_sum   <= '0;
                    r_count <= '0;
                end else begin
                    r_sum   <= n_sum;
                    r_count <= r_count + 1'b1;
                end
            end else begin
                r_show_low <= !r_show_low;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (s1_go && (r_s1_cmd == CMD_TICK)) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_go && (r_s1_cmd == CMD_TICK)) begin
            r_out_seg   <= SEG_CODES[digit];
            r_out_high  <= !r_show_low;
            r_out_low   <= r_show_low;
            r_out_speed <= r_speed;
        end
    end

    assign o_out.valid         = r_out_valid;
    assign o_out.segments      = r_out_seg;
    assign o_out.high_digit_on = r_out_high;
    assign o_out.low_digit_on  = r_out_low;
    assign o_out.speed         = r_out_speed;

endmodule

// ===== rtl/asd_check.sv =====
// Port-level checks of the speed display, attached to the top level by bind.
module asd_check
    import asd_pkg::*;
(
    input logic                  i_clk,
    input logic                  i_rst_n,
    input logic                  i_out_valid,
    input logic                  i_out_ready,
    input logic [SEG_BITS-1:0]   i_segments,
    input logic                  i_high_digit_on,
    input logic                  i_low_digit_on,
    input logic [SPEED_BITS-1:0] i_speed
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid)
        else $error("result dropped while stalled");

    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> $stable(i_segments) && $stable(i_speed)
            && $stable(i_high_digit_on) && $stable(i_low_digit_on))
        else $error("stalled result changed");

    // Exactly one of the two digits is enabled in every result.
    a_one_digit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> (i_high_digit_on != i_low_digit_on))
        else $error("digit enables not exclusive");

    // The stored speed is always capped to two decimal digits.
    a_speed_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> (i_speed <= SPEED_LIMIT))
        else $error("speed above two digits");

endmodule

bind adc_average_speed_display_top asd_check u_asd_check (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_out_valid     (o_out.valid),
    .i_out_ready     (o_out.ready),
    .i_segments      (o_out.segments),
    .i_high_digit_on (o_out.high_digit_on),
    .i_low_digit_on  (o_out.low_digit_on),
    .i_speed         (o_out.speed)
);

// ===== tb/sv/tb.sv =====
// Self-checking testbench for the averaging speed display with randomized handshakes.
`timescale 1ns / 100ps

module tb;
    import asd_pkg::*;

    localparam int unsigned READING_MAX    = (1 << SAMPLE_BITS) - 1;
    localparam int unsigned READING_HALF   = READING_MAX >> 1;
    localparam int unsigned SPEED_CAP      = 99;
    localparam int unsigned MEAN_LENGTH    = 8;
    localparam int          WATCHDOG_LIMIT = 2000;
    localparam int          RANDOM_PER_SET = 50;

    localparam logic [6:0] DIGIT_SEGS [10] = '{
        7'h77, 7'h41, 7'h3B, 7'h6B, 7'h4D, 7'h6E, 7'h7E, 7'h43, 7'h7F, 7'h4F
    };

    typedef struct packed {
        logic                   command;
        logic [SAMPLE_BITS-1:0] sample;
    } adc_item_t;

    typedef struct packed {
        logic [SEG_BITS-1:0]   segments;
        logic                  high_on;
        logic                  low_on;
        logic [SPEED_BITS-1:0] speed;
    } digit_word_t;

    typedef enum logic [1:0] {RX_OPEN, RX_RANDOM, RX_PERIODIC} rx_mode_t;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;

    asd_in_if  in_ch ();
    asd_out_if out_ch ();
    asd_cfg_if cfg_ch ();

    adc_average_speed_display_top i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch),
        .i_cfg   (cfg_ch)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // Predictor state, mirrors the block after reset.
    int unsigned speed_sum     = 0;
    int unsigned samples_seen  = 0;
    int unsigned shown_speed   = 0;
    logic        units_next    = 1'b0;
    int unsigned full_scale    = 50;

    adc_item_t   adc_items [$];
    digit_word_t expected_digits [$];
    int          items_queued   = 0;
    int          items_accepted = 0;
    int          err_count      = 0;

    task automatic report_error(input string msg);
        $display("tb: mismatch at %0t: %s", $time, msg);
        err_count++;
    endtask

    task automatic predict_display(input adc_item_t item);
        int unsigned mean;
        int unsigned scaled;
        int unsigned digit;
        digit_word_t word;
        if (item.command == CMD_SAMPLE) begin
            speed_sum += item.sample;
            samples_seen++;
            if (samples_seen >= MEAN_LENGTH) begin
                mean = speed_sum / MEAN_LENGTH;
                scaled = (mean * full_scale + READING_HALF) / READING_MAX;
                shown_speed = (scaled > SPEED_CAP) ? SPEED_CAP : scaled;
                speed_sum = 0;
                samples_seen = 0;
            end
        end else begin
            digit = units_next ? shown_speed % 10 : (shown_speed / 10) % 10;
            word.segments = DIGIT_SEGS[digit];
            word.high_on  = !units_next;
            word.low_on   = units_next;
            word.speed    = shown_speed[SPEED_BITS-1:0];
            expected_digits.push_back(word);
            units_next = !units_next;
        end
    endtask

    task automatic add_item(input logic command, input logic [SAMPLE_BITS-1:0] sample);
        adc_item_t item;
        item.command = command;
        item.sample  = sample;
        adc_items.push_back(item);
        items_queued++;
    endtask

    task automatic add_random_items(input int count);
        logic [SAMPLE_BITS-1:0] value;
        for (int i = 0; i < count; i++) begin
            case ($urandom_range(0, 4))
                0: value = '0;
                1: value = '1;
                default: value = SAMPLE_BITS'($urandom);
            endcase
            add_item(($urandom_range(0, 9) < 3) ? CMD_TICK : CMD_SAMPLE, value);
        end
    endtask

    // Waits until every queued item went in and every result came out.
    task automatic wait_quiet(input int settle);
        while (items_accepted != items_queued || expected_digits.size() != 0)
            @(posedge i_clk);
        repeat (settle) @(posedge i_clk);
    endtask

    task automatic write_full_scale(input logic [SPEED_BITS-1:0] value);
        @(posedge i_clk);
        cfg_ch.valid <= 1'b1;
        cfg_ch.data  <= value;
        @(posedge i_clk);
        while (!cfg_ch.ready) @(posedge i_clk);
        cfg_ch.valid <= 1'b0;
    endtask

    // Sender: bursts of items separated by random gaps.
    int burst_left = 1;
    int gap_left   = 0;

    always @(posedge i_clk) begin : feed_items
        adc_item_t nxt;
        logic      give;
        if (i_rst_n && (!in_ch.valid || in_ch.ready)) begin
            give = 1'b0;
            if (gap_left != 0) begin
                gap_left--;
            end else if (adc_items.size() != 0) begin
                nxt = adc_items.pop_front();
                give = 1'b1;
                burst_left--;
                if (burst_left <= 0) begin
                    burst_left = $urandom_range(1, 24);
                    gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
                end
            end
            in_ch.valid <= give;
            if (give) begin
                in_ch.command <= nxt.command;
                in_ch.sample  <= nxt.sample;
            end
        end
    end

    // Receiver: switches between always ready, random stalls and periodic stalls.
    int       rx_count = 0;
    rx_mode_t rx_mode  = RX_OPEN;

    always @(posedge i_clk) begin
        rx_count++;
        if (rx_count % 128 == 0)
            rx_mode = rx_mode_t'($urandom_range(0, 2));
        case (rx_mode)
            RX_OPEN:   out_ch.ready <= 1'b1;
            RX_RANDOM: out_ch.ready <= 1'($urandom_range(0, 1));
            default:   out_ch.ready <= (rx_count % 16) > 9;
        endcase
    end

    always @(posedge i_clk) begin : watch_channels
        digit_word_t got;
        digit_word_t want;
        adc_item_t   item;
        if (i_rst_n) begin
            if (cfg_ch.valid && cfg_ch.ready)
                full_scale = cfg_ch.data;
            if (out_ch.valid && out_ch.ready) begin
                got.segments = out_ch.segments;
                got.high_on  = out_ch.high_digit_on;
                got.low_on   = out_ch.low_digit_on;
                got.speed    = out_ch.speed;
                if (expected_digits.size() == 0) begin
                    report_error($sformatf("result with nothing expected, speed %0d",
                                           got.speed));
                end else begin
                    want = expected_digits.pop_front();
                    if (got.segments !== want.segments)
                        report_error($sformatf("segments %h, expected %h",
                                               got.segments, want.segments));
                    if (got.high_on !== want.high_on)
                        report_error($sformatf("high_digit_on %b, expected %b",
                                               got.high_on, want.high_on));
                    if (got.low_on !== want.low_on)
                        report_error($sformatf("low_digit_on %b, expected %b",
                                               got.low_on, want.low_on));
                    if (got.speed !== want.speed)
                        report_error($sformatf("speed %0d, expected %0d",
                                               got.speed, want.speed));
                end
            end
            if (in_ch.valid && in_ch.ready) begin
                item.command = in_ch.command;
                item.sample  = in_ch.sample;
                predict_display(item);
                items_accepted++;
            end
        end
    end

    int idle_cycles = 0;

    always @(posedge i_clk) begin
        if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)
                || (cfg_ch.valid && cfg_ch.ready))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("tb: errors");
            $finish;
        end
    end

    initial begin
        logic [SPEED_BITS-1:0] scale;
        in_ch.valid   = 1'b0;
        in_ch.command = CMD_SAMPLE;
        in_ch.sample  = '0;
        out_ch.ready  = 1'b1;
        cfg_ch.valid  = 1'b0;
        cfg_ch.data   = '0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // At reset the speed is zero and the tens digit comes first; then a full
        // reading at the reset scale shows 50 on both digits.
        add_item(CMD_TICK, '0);
        repeat (MEAN_LENGTH) add_item(CMD_SAMPLE, '1);
        add_item(CMD_TICK, '1);
        add_item(CMD_TICK, '0);
        add_random_items(RANDOM_PER_SET);
        wait_quiet(6);

        for (int set = 0; set < 7; set++) begin
            case (set)
                0: scale = 7'd127;
                1: scale = 7'd0;
                2: scale = 7'd1;
                3: scale = 7'd99;
                default: scale = SPEED_BITS'($urandom_range(0, 127));
            endcase
            write_full_scale(scale);
            // A full reading at a scale above 99 must saturate to 99.
            if (set == 0) begin
                repeat (MEAN_LENGTH) add_item(CMD_SAMPLE, '1);
                add_item(CMD_TICK, '0);
            end
            add_random_items(RANDOM_PER_SET);
            wait_quiet(6);
        end

        wait_quiet(10);
        if (err_count == 0)
            $display("tb: clean");
        else
            $display("tb: errors");
        $finish;
    end

endmodule

// ===== files.f =====
rtl/asd_pkg.sv
rtl/asd_if.sv
rtl/asd_scale.sv
rtl/adc_average_speed_display_top.sv
rtl/asd_check.sv
tb/sv/tb.sv
